FILE: rtl/trd_pkg.sv
// Shared types and constants of the triangle rasterizer with depth test.
package trd_pkg;

   localparam int MAC_A_W    = 18;
   localparam int MAC_B_W    = 33;
   localparam int MAC_P_W    = MAC_A_W + MAC_B_W;
   localparam int ACC_W      = 70;
   localparam int HI_SHIFT   = 17;
   localparam int DIV_REM_W  = 36;
   localparam int DIV_NUM_W  = 41;
   localparam int DIV_DEN_W  = 35;
   localparam int DIV_CNT_W  = 6;

   typedef enum logic [2:0] {
      MAC_NOP,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB,
      MAC_LOAD_HI,
      MAC_ADD_HI
   } mac_op_type;

   typedef struct packed {
      mac_op_type                  op;
      logic signed [MAC_A_W-1:0]   a;
      logic signed [MAC_B_W-1:0]   b;
   } mac_ctl_type;

   typedef struct packed {
      logic                        start;
      logic [DIV_REM_W-1:0]        rem_init;
      logic [DIV_NUM_W-1:0]        dividend;
      logic [DIV_DEN_W-1:0]        divisor;
      logic [DIV_CNT_W-1:0]        count;
   } div_ctl_type;

   typedef struct packed {
      logic                        busy;
      logic                        done;
      logic [DIV_NUM_W-1:0]        quotient;
   } div_sts_type;

endpackage

FILE: rtl/trd_mac.sv
// Shared signed multiplier with a registered product and a wide accumulator.
module trd_mac
   import trd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctl_type              ctl,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [MAC_P_W-1:0] prod_ff;
   mac_op_type                op_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   prod_hi;

   assign prod_ext = {{(ACC_W-MAC_P_W){prod_ff[MAC_P_W-1]}}, prod_ff};
   assign prod_hi  = prod_ext <<< HI_SHIFT;
   assign acc      = acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= ctl.a * ctl.b;
      if (reset) begin
         op_ff <= MAC_NOP;
      end else begin
         op_ff <= ctl.op;
      end
      case (op_ff)
         MAC_LOAD:    acc_ff <= prod_ext;
         MAC_ADD:     acc_ff <= acc_ff + prod_ext;
         MAC_SUB:     acc_ff <= acc_ff - prod_ext;
         MAC_LOAD_HI: acc_ff <= prod_hi;
         MAC_ADD_HI:  acc_ff <= acc_ff + prod_hi;
         default:     acc_ff <= acc_ff;
      endcase
   end

endmodule

FILE: rtl/trd_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
module trd_div
   import trd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctl_type  ctl,
   output div_sts_type  sts
);

   logic [DIV_REM_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] sh_ff;
   logic [DIV_NUM_W-1:0] q_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_REM_W:0]   shifted;
   logic [DIV_REM_W+1:0] trial;
   logic                 qbit;
   logic [DIV_REM_W-1:0] rem_in;

   assign shifted = {rem_ff, sh_ff[DIV_NUM_W-1]};
   assign trial   = {1'b0, shifted} - {{(DIV_REM_W+2-DIV_DEN_W){1'b0}}, den_ff};
   assign qbit    = ~trial[DIV_REM_W+1];
   assign rem_in  = qbit ? trial[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (ctl.start) begin
         rem_ff <= ctl.rem_init;
         sh_ff  <= ctl.dividend;
         den_ff <= ctl.divisor;
         q_ff   <= '0;
         cnt_ff <= ctl.count;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_ff << 1;
         q_ff   <= {q_ff[DIV_NUM_W-2:0], qbit};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

endmodule

FILE: rtl/trd_depth_mem.sv
// Depth store memory with one write port and one registered read port.
module trd_depth_mem #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

FILE: rtl/triangle_rasterizer_depth_test.sv
// Top level of the half-space triangle rasterizer with a per-pixel depth test.
// After reset the block clears the depth store, one entry per cycle, through all
// MAX_WIDTH*MAX_HEIGHT entries and accepts no transaction until that is done.
// Every transaction gives exactly one result. A triangle load runs edge
// products on the shared multiplier, then three reciprocals of w on the
// shared radix-2 divider; a rejected triangle stops after the edge products.
// A covered pixel step runs six partial products and a division for 32
// quotient bits; an uncovered pixel skips both, and with no triangle loaded
// the step gives only an idle result. A held result stalls the finish state.
// The block takes one transaction at a time, and a finished result waits in
// an output register so the next transaction can enter while it is held.
module triangle_rasterizer_depth_test
   import trd_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w
   input  logic [167:0] req_tdata,
   // action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pixel_x, pixel_y, write_pixel, color, depth_value, zero pad
   output logic [71:0]  rsp_tdata,
   // kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [7:0]   csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = 37;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_PIXEL  = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [45:0] GRAY_SCALE = 46'd16320;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SMUL,
      S_RDIV_GO,
      S_RDIV_WAIT,
      S_PMUL,
      S_PDIV_WAIT,
      S_PWR,
      S_FINISH
   } state_type;

   function automatic logic signed [16:0] vd(input logic signed [15:0] u,
                                             input logic signed [15:0] v);
      return {u[15], u} - {v[15], v};
   endfunction

   function automatic logic signed [11:0] to_pix(input logic signed [15:0] v);
      logic signed [16:0] t;
      t = v[15] ? ({v[15], v} + 17'sd15) : {v[15], v};
      return t[15:4];
   endfunction

   function automatic logic signed [MAC_A_W-1:0] ext_a(input logic signed [16:0] v);
      return {v[16], v};
   endfunction

   function automatic logic signed [MAC_B_W-1:0] ext_b(input logic signed [17:0] v);
      return {{(MAC_B_W-18){v[17]}}, v};
   endfunction

   function automatic logic signed [WW-1:0] step_of(input logic signed [16:0] v);
      return {{(WW-21){v[16]}}, v, 4'b0000};
   endfunction

   state_type                state_ff;
   logic [3:0]               cnt_ff;
   logic [1:0]               ri_ff;
   logic [AW-1:0]            clr_ff;
   logic                     active_ff;
   logic [7:0]               fw_ff;
   logic [7:0]               fh_ff;
   logic signed [15:0]       ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [23:0]              wa_ff, wb_ff, wc_ff;
   logic [33:0]              d_ff;
   logic                     dpos_ff;
   logic signed [WW-1:0]     rw_ff [3];
   logic signed [WW-1:0]     pw_ff [3];
   logic [31:0]              inv_ff [3];
   logic [XW-1:0]            x0_ff, x1_ff, sx_ff;
   logic [YW-1:0]            y0_ff, y1_ff, sy_ff;
   logic                     cov_ff;
   logic [31:0]              q_ff;
   logic [1:0]               res_kind_ff;
   logic [6:0]               res_x_ff, res_y_ff;
   logic                     res_wr_ff, res_last_ff;
   logic [23:0]              res_color_ff;
   logic [31:0]              res_depth_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               out_kind_ff;
   logic [6:0]               out_x_ff, out_y_ff;
   logic                     out_wr_ff, out_last_ff;
   logic [23:0]              out_color_ff;
   logic [31:0]              out_depth_ff;

   mac_ctl_type              mac_ctl;
   logic signed [ACC_W-1:0]  acc;
   div_ctl_type              div_ctl;
   div_sts_type              div_sts;

   logic                     req_fire;
   logic signed [11:0]       pax, pay, pbx, pby, pcx, pcy;
   logic signed [11:0]       xmin, xmax, ymin, ymax, x0c, x1c, y0c, y1c;
   logic [11:0]              fw_lim, fh_lim;
   logic signed [11:0]       fwm1, fhm1;
   logic                     box_empty;
   logic signed [17:0]       px_q, py_q;
   logic                     covered;
   logic                     is_last;
   logic signed [WW-1:0]     stx [3];
   logic signed [WW-1:0]     sty [3];
   logic [AW-1:0]            scan_addr;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [31:0]              mem_wdata;
   logic [31:0]              mem_rdata;
   logic                     pix_write;
   logic [45:0]              gray_prod;
   logic [7:0]               gray;
   logic [23:0]              wsel;
   logic [31:0]              inv_sat;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Bounding box in whole pixels, clipped to the frame.
   assign pax = to_pix(ax_ff);
   assign pay = to_pix(ay_ff);
   assign pbx = to_pix(bx_ff);
   assign pby = to_pix(by_ff);
   assign pcx = to_pix(cx_ff);
   assign pcy = to_pix(cy_ff);

   always_comb begin
      xmin = (pax < pbx) ? pax : pbx;
      xmin = (xmin < pcx) ? xmin : pcx;
      ymin = (pay < pby) ? pay : pby;
      ymin = (ymin < pcy) ? ymin : pcy;
      xmax = (pax > pbx) ? pax : pbx;
      xmax = (xmax > pcx) ? xmax : pcx;
      ymax = (pay > pby) ? pay : pby;
      ymax = (ymax > pcy) ? ymax : pcy;
      if (fw_ff == 8'd0) begin
         fw_lim = 12'd1;
      end else if ({4'b0, fw_ff} > 12'(MAX_WIDTH)) begin
         fw_lim = 12'(MAX_WIDTH);
      end else begin
         fw_lim = {4'b0, fw_ff};
      end
      if (fh_ff == 8'd0) begin
         fh_lim = 12'd1;
      end else if ({4'b0, fh_ff} > 12'(MAX_HEIGHT)) begin
         fh_lim = 12'(MAX_HEIGHT);
      end else begin
         fh_lim = {4'b0, fh_ff};
      end
      fwm1 = signed'(fw_lim - 12'd1);
      fhm1 = signed'(fh_lim - 12'd1);
      x0c  = xmin[11] ? 12'sd0 : xmin;
      y0c  = ymin[11] ? 12'sd0 : ymin;
      x1c  = (xmax > fwm1) ? fwm1 : xmax;
      y1c  = (ymax > fhm1) ? fhm1 : ymax;
      box_empty = (x0c > x1c) || (y0c > y1c);
      px_q = {2'b00, x0c, 4'b0000};
      py_q = {2'b00, y0c, 4'b0000};
   end

   assign stx[0] = step_of(vd(by_ff, cy_ff));
   assign stx[1] = step_of(vd(cy_ff, ay_ff));
   assign stx[2] = step_of(vd(ay_ff, by_ff));
   assign sty[0] = step_of(vd(cx_ff, bx_ff));
   assign sty[1] = step_of(vd(ax_ff, cx_ff));
   assign sty[2] = step_of(vd(bx_ff, ax_ff));

   assign covered = !pw_ff[0][WW-1] && (|pw_ff[0]) &&
                    !pw_ff[1][WW-1] && (|pw_ff[1]) &&
                    !pw_ff[2][WW-1] && (|pw_ff[2]);
   assign is_last = (sx_ff == x1_ff) && (sy_ff == y1_ff);

   // Multiplier schedule: edge products during setup, weight times 1/w per pixel.
   always_comb begin
      mac_ctl.op = MAC_NOP;
      mac_ctl.a  = '0;
      mac_ctl.b  = '0;
      if (state_ff == S_SMUL) begin
         case (cnt_ff)
            4'd0: begin
               mac_ctl.op = MAC_LOAD;
               mac_ctl.a  = ext_a(vd(bx_ff, ax_ff));
               mac_ctl.b  = ext_b(ext_a(vd(cy_ff, ay_ff)));
            end
            4'd1: begin
               mac_ctl.op = MAC_SUB;
               mac_ctl.a  = ext_a(vd(cx_ff, ax_ff));
               mac_ctl.b  = ext_b(ext_a(vd(by_ff, ay_ff)));
            end
            4'd2: begin
               mac_ctl.op = MAC_LOAD;
               mac_ctl.a  = ext_a(vd(cx_ff, bx_ff));
               mac_ctl.b  = ext_b(py_q - {{2{by_ff[15]}}, by_ff});
            end
            4'd3: begin
               mac_ctl.op = MAC_SUB;
               mac_ctl.a  = ext_a(vd(cy_ff, by_ff));
               mac_ctl.b  = ext_b(px_q - {{2{bx_ff[15]}}, bx_ff});
            end
            4'd4: begin
               mac_ctl.op = MAC_LOAD;
               mac_ctl.a  = ext_a(vd(ax_ff, cx_ff));
               mac_ctl.b  = ext_b(py_q - {{2{cy_ff[15]}}, cy_ff});
            end
            4'd5: begin
               mac_ctl.op = MAC_SUB;
               mac_ctl.a  = ext_a(vd(ay_ff, cy_ff));
               mac_ctl.b  = ext_b(px_q - {{2{cx_ff[15]}}, cx_ff});
            end
            4'd6: begin
               mac_ctl.op = MAC_LOAD;
               mac_ctl.a  = ext_a(vd(bx_ff, ax_ff));
               mac_ctl.b  = ext_b(py_q - {{2{ay_ff[15]}}, ay_ff});
            end
            4'd7: begin
               mac_ctl.op = MAC_SUB;
               mac_ctl.a  = ext_a(vd(by_ff, ay_ff));
               mac_ctl.b  = ext_b(px_q - {{2{ax_ff[15]}}, ax_ff});
            end
            default: begin
               mac_ctl.op = MAC_NOP;
            end
         endcase
      end else if (state_ff == S_PMUL) begin
         case (cnt_ff)
            4'd0: begin
               mac_ctl.op = MAC_LOAD_HI;
               mac_ctl.a  = {1'b0, pw_ff[0][33:17]};
               mac_ctl.b  = {1'b0, inv_ff[0]};
            end
            4'd1: begin
               mac_ctl.op = MAC_ADD;
               mac_ctl.a  = {1'b0, pw_ff[0][16:0]};
               mac_ctl.b  = {1'b0, inv_ff[0]};
            end
            4'd2: begin
               mac_ctl.op = MAC_ADD_HI;
               mac_ctl.a  = {1'b0, pw_ff[1][33:17]};
               mac_ctl.b  = {1'b0, inv_ff[1]};
            end
            4'd3: begin
               mac_ctl.op = MAC_ADD;
               mac_ctl.a  = {1'b0, pw_ff[1][16:0]};
               mac_ctl.b  = {1'b0, inv_ff[1]};
            end
            4'd4: begin
               mac_ctl.op = MAC_ADD_HI;
               mac_ctl.a  = {1'b0, pw_ff[2][33:17]};
               mac_ctl.b  = {1'b0, inv_ff[2]};
            end
            4'd5: begin
               mac_ctl.op = MAC_ADD;
               mac_ctl.a  = {1'b0, pw_ff[2][16:0]};
               mac_ctl.b  = {1'b0, inv_ff[2]};
            end
            default: begin
               mac_ctl.op = MAC_NOP;
            end
         endcase
      end
   end

   always_comb begin
      case (ri_ff)
         2'd0:    wsel = wa_ff;
         2'd1:    wsel = wb_ff;
         default: wsel = wc_ff;
      endcase
   end

   // The quotient of a pixel is known to fit in 32 bits, so the upper part of
   // the numerator already sits below the area and seeds the remainder.
   always_comb begin
      div_ctl.start    = 1'b0;
      div_ctl.rem_init = '0;
      div_ctl.dividend = {1'b1, {(DIV_NUM_W-1){1'b0}}};
      div_ctl.divisor  = {{(DIV_DEN_W-24){1'b0}}, wsel};
      div_ctl.count    = DIV_CNT_W'(DIV_NUM_W);
      if (state_ff == S_RDIV_GO) begin
         div_ctl.start = 1'b1;
      end else if (state_ff == S_PMUL && cnt_ff == 4'd7) begin
         div_ctl.start    = 1'b1;
         div_ctl.rem_init = acc[67:32];
         div_ctl.dividend = {acc[31:0], {(DIV_NUM_W-32){1'b0}}};
         div_ctl.divisor  = {{(DIV_DEN_W-34){1'b0}}, d_ff};
         div_ctl.count    = DIV_CNT_W'(32);
      end
   end

   assign inv_sat = (|div_sts.quotient[DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF
                                                        : div_sts.quotient[31:0];

   assign scan_addr = AW'(sy_ff) * AW'(MAX_WIDTH) + AW'(sx_ff);
   assign pix_write = cov_ff && (q_ff > mem_rdata);
   assign gray_prod = {14'b0, q_ff} * GRAY_SCALE;
   assign gray      = (|gray_prod[45:32]) ? 8'hFF : gray_prod[31:24];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_addr;
      mem_wdata = q_ff;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == S_PWR) begin
         mem_we = pix_write;
      end
   end

   trd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   trd_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   trd_depth_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_depth_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (scan_addr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= 8'd128;
         fh_ff        <= 8'd128;
         cnt_ff       <= '0;
         ri_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_FRAME_WIDTH:  fw_ff <= csr_wdata;
               REG_FRAME_HEIGHT: fh_ff <= csr_wdata;
               default:          fw_ff <= fw_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  res_x_ff     <= '0;
                  res_y_ff     <= '0;
                  res_wr_ff    <= 1'b0;
                  res_color_ff <= '0;
                  res_depth_ff <= '0;
                  res_last_ff  <= 1'b0;
                  cnt_ff       <= '0;
                  if (!req_tuser) begin
                     ax_ff     <= req_tdata[15:0];
                     ay_ff     <= req_tdata[31:16];
                     wa_ff     <= req_tdata[55:32];
                     cx_ff     <= req_tdata[71:56];
                     cy_ff     <= req_tdata[87:72];
                     wc_ff     <= req_tdata[111:88];
                     bx_ff     <= req_tdata[127:112];
                     by_ff     <= req_tdata[143:128];
                     wb_ff     <= req_tdata[167:144];
                     active_ff <= 1'b0;
                     state_ff  <= S_SMUL;
                  end else if (!active_ff) begin
                     res_kind_ff <= KIND_IDLE;
                     state_ff    <= S_FINISH;
                  end else begin
                     cov_ff <= covered;
                     q_ff   <= '0;
                     if (covered) begin
                        state_ff <= S_PMUL;
                     end else begin
                        state_ff <= S_PWR;
                     end
                  end
               end
            end
            S_SMUL: begin
               cnt_ff <= cnt_ff + 4'd1;
               case (cnt_ff)
                  4'd3: begin
                     d_ff    <= acc[33:0];
                     dpos_ff <= !acc[ACC_W-1] && (|acc);
                  end
                  4'd5: rw_ff[0] <= acc[WW-1:0];
                  4'd7: rw_ff[1] <= acc[WW-1:0];
                  4'd9: begin
                     if (wa_ff == 24'd0 || !dpos_ff || box_empty) begin
                        res_kind_ff <= KIND_REJECT;
                        state_ff    <= S_FINISH;
                     end else begin
                        rw_ff[2] <= acc[WW-1:0];
                        pw_ff[0] <= rw_ff[0];
                        pw_ff[1] <= rw_ff[1];
                        pw_ff[2] <= acc[WW-1:0];
                        x0_ff    <= x0c[XW-1:0];
                        x1_ff    <= x1c[XW-1:0];
                        y0_ff    <= y0c[YW-1:0];
                        y1_ff    <= y1c[YW-1:0];
                        sx_ff    <= x0c[XW-1:0];
                        sy_ff    <= y0c[YW-1:0];
                        ri_ff    <= '0;
                        state_ff <= S_RDIV_GO;
                     end
                  end
                  default: begin
                     d_ff <= d_ff;
                  end
               endcase
            end
            S_RDIV_GO: begin
               state_ff <= S_RDIV_WAIT;
            end
            S_RDIV_WAIT: begin
               if (div_sts.done) begin
                  inv_ff[ri_ff] <= inv_sat;
                  if (ri_ff == 2'd2) begin
                     active_ff   <= 1'b1;
                     res_kind_ff <= KIND_ACCEPT;
                     state_ff    <= S_FINISH;
                  end else begin
                     ri_ff    <= ri_ff + 2'd1;
                     state_ff <= S_RDIV_GO;
                  end
               end
            end
            S_PMUL: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) begin
                  state_ff <= S_PDIV_WAIT;
               end
            end
            S_PDIV_WAIT: begin
               if (div_sts.done) begin
                  q_ff     <= div_sts.quotient[31:0];
                  state_ff <= S_PWR;
               end
            end
            S_PWR: begin
               res_kind_ff  <= KIND_PIXEL;
               res_x_ff     <= 7'(sx_ff);
               res_y_ff     <= 7'(sy_ff);
               res_wr_ff    <= pix_write;
               res_color_ff <= cov_ff ? {gray, gray, gray} : 24'd0;
               res_depth_ff <= q_ff;
               res_last_ff  <= is_last;
               if (is_last) begin
                  active_ff <= 1'b0;
               end else if (sx_ff < x1_ff) begin
                  sx_ff <= sx_ff + XW'(1);
                  for (int k = 0; k < 3; k++) begin
                     pw_ff[k] <= pw_ff[k] + stx[k];
                  end
               end else begin
                  sx_ff <= x0_ff;
                  sy_ff <= sy_ff + YW'(1);
                  for (int k = 0; k < 3; k++) begin
                     rw_ff[k] <= rw_ff[k] + sty[k];
                     pw_ff[k] <= rw_ff[k] + sty[k];
                  end
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  out_kind_ff  <= res_kind_ff;
                  out_x_ff     <= res_x_ff;
                  out_y_ff     <= res_y_ff;
                  out_wr_ff    <= res_wr_ff;
                  out_color_ff <= res_color_ff;
                  out_depth_ff <= res_depth_ff;
                  out_last_ff  <= res_last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_depth_ff, out_color_ff, out_wr_ff, out_y_ff, out_x_ff};

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_scan_in_box: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (x0_ff <= x1_ff && y0_ff <= y1_ff &&
                     sx_ff <= x1_ff && sy_ff <= y1_ff && sx_ff >= x0_ff))
      else $error("scan position outside the bounding box");

   a_load_drops: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser) |=> !active_ff)
      else $error("triangle still active after a load transaction");
`endif

endmodule
